### rtl/core/atce_pkg.sv
// Shared types and constants of the text console engine.
`timescale 1ns / 1ps
`default_nettype none
package atce_pkg;

  localparam int GLYPH_W     = 8;
  localparam int GLYPH_H     = 16;
  localparam int PARAM_SLOTS = 4;
  localparam int MAX_RESULTS = 4;
  localparam int SLOT_IDX_W  = $clog2(PARAM_SLOTS);
  localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

  // Drawing command codes.
  typedef enum logic [1:0] {
    CMD_FILL   = 2'd0,
    CMD_GLYPH  = 2'd1,
    CMD_SCROLL = 2'd2
  } cmd_e;

  // One drawing command.
  typedef struct packed {
    cmd_e        command;
    logic [11:0] x_px;
    logic [11:0] y_px;
    logic [11:0] width_px;
    logic [11:0] height_px;
    logic [23:0] paint_color;
    logic [23:0] back_color;
    logic [7:0]  glyph_code;
  } cmd_t;

  // All commands caused by one byte.
  typedef struct packed {
    logic [RES_CNT_W-1:0]         count;
    cmd_t [MAX_RESULTS-1:0] cmds;
  } job_t;

endpackage
`default_nettype wire

### rtl/core/atce_if.sv
// Channel interfaces for console bytes and drawing commands.
`timescale 1ns / 1ps
`default_nettype none
interface atce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_write;

  modport source (output valid, output byte_in, output end_of_write, input ready);
  modport sink (input valid, input byte_in, input end_of_write, output ready);
endinterface

interface atce_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [11:0] x_px;
  logic [11:0] y_px;
  logic [11:0] width_px;
  logic [11:0] height_px;
  logic [23:0] paint_color;
  logic [23:0] back_color;
  logic [7:0]  glyph_code;
  logic        last_result;

  modport source (output valid, output command, output x_px, output y_px,
                  output width_px, output height_px, output paint_color,
                  output back_color, output glyph_code, output last_result,
                  input ready);
  modport sink (input valid, input command, input x_px, input y_px,
                input width_px, input height_px, input paint_color,
                input back_color, input glyph_code, input last_result,
                output ready);
endinterface
`default_nettype wire

### rtl/core/atce_front.sv
// Front end: escape parser, cursor and color state, builds the commands of each byte.
`timescale 1ns / 1ps
`default_nettype none
module atce_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  atce_in_if.sink                            in_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [atce_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [atce_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                          q_ready_i,
  output logic                               q_push_o,
  output atce_pkg::job_t                     q_job_o
);

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_ESC    = 2'd1;
  localparam logic [1:0] MODE_CSI    = 2'd2;
  localparam logic [1:0] MODE_PRIV   = 2'd3;

  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LBR = 8'h5B;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_QUES = 8'h3F;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_H   = 8'h48;
  localparam logic [7:0] CH_J   = 8'h4A;
  localparam logic [7:0] CH_K   = 8'h4B;
  localparam logic [7:0] CH_M   = 8'h6D;
  localparam logic [7:0] CH_LO_H = 8'h68;
  localparam logic [7:0] CH_LO_L = 8'h6C;

  localparam int GW_SH = $clog2(atce_pkg::GLYPH_W);
  localparam int GH_SH = $clog2(atce_pkg::GLYPH_H);
  localparam int SW    = atce_pkg::SLOT_IDX_W;

  logic [11:0] scr_w_q, scr_h_q;
  logic [1:0]  mode_q, mode_d;
  logic [15:0] dv_q, dv_d;
  logic [3:0]  dc_q, dc_d;
  logic [atce_pkg::PARAM_SLOTS-1:0][15:0] slots_q, slots_d;
  logic [SW-1:0] idx_q, idx_d;
  logic [7:0]  row_q, row_d;
  logic [8:0]  col_q, col_d;
  logic [23:0] fore_q, fore_d, grd_q, grd_d;
  logic        rev_q, rev_d, shown_q, shown_d, disc_q, disc_d;

  logic        fire;
  logic [7:0]  rows;
  logic [8:0]  cols;

  // Append one command to the list of a byte.
  function automatic atce_pkg::job_t put(input atce_pkg::job_t j, input atce_pkg::cmd_t c);
    atce_pkg::job_t r;
    r = j;
    if (r.count < atce_pkg::RES_CNT_W'(atce_pkg::MAX_RESULTS)) begin
      r.cmds[r.count[atce_pkg::RES_IDX_W-1:0]] = c;
      r.count = r.count + 1'b1;
    end
    return r;
  endfunction

  function automatic atce_pkg::cmd_t mk(input atce_pkg::cmd_e k, input logic [11:0] x,
                                        input logic [11:0] y, input logic [11:0] w,
                                        input logic [11:0] h, input logic [23:0] paint,
                                        input logic [23:0] back, input logic [7:0] g);
    atce_pkg::cmd_t c;
    c.command = k;
    c.x_px = x;
    c.y_px = y;
    c.width_px = w;
    c.height_px = h;
    c.paint_color = paint;
    c.back_color = back;
    c.glyph_code = g;
    return c;
  endfunction

  // Solid cell at a text position.
  function automatic atce_pkg::cmd_t cursor_cell(input logic [9:0] c, input logic [8:0] r,
                                                 input logic [23:0] color);
    return mk(atce_pkg::CMD_FILL, 12'({c, {GW_SH{1'b0}}}), 12'({r, {GH_SH{1'b0}}}),
              12'(atce_pkg::GLYPH_W), 12'(atce_pkg::GLYPH_H), color, 24'd0, 8'd0);
  endfunction

  // One select graphic rendition code applied to {fore, ground, reverse}.
  function automatic logic [48:0] sgr(input logic [15:0] p, input logic [48:0] s);
    logic [23:0] f, g;
    logic        rv;
    {f, g, rv} = s;
    unique case (p)
      16'd0:  begin f = 24'hFFFFFF; g = 24'h000000; rv = 1'b0; end
      16'd7:  rv = 1'b1;
      16'd27: rv = 1'b0;
      16'd30: f = 24'h414868;
      16'd31: f = 24'hF7768E;
      16'd32: f = 24'h9ECE6A;
      16'd33: f = 24'hE0AF68;
      16'd34: f = 24'h7AA2F7;
      16'd35: f = 24'hBB9AF7;
      16'd36: f = 24'h7DCFFF;
      16'd37: f = 24'hA9B1D6;
      16'd39: f = 24'hC0CAF5;
      16'd40: g = 24'h1A1B26;
      16'd41: g = 24'hF7768E;
      16'd42: g = 24'h9ECE6A;
      16'd43: g = 24'hE0AF68;
      16'd44: g = 24'h7AA2F7;
      16'd45: g = 24'hBB9AF7;
      16'd46: g = 24'h7DCFFF;
      16'd47: g = 24'hA9B1D6;
      16'd49: g = 24'h000000;
      16'd90: f = 24'h565F89;
      16'd91: f = 24'hFF9E9E;
      16'd92: f = 24'hC3E88D;
      16'd93: f = 24'hFFD580;
      16'd94: f = 24'h82AAFF;
      16'd95: f = 24'hC3A6FF;
      16'd96: f = 24'hB4F9F8;
      16'd97: f = 24'hC0CAF5;
      default: ;
    endcase
    return {f, g, rv};
  endfunction

  function automatic logic [SW-1:0] next_idx(input logic [SW-1:0] i);
    return (i == SW'(atce_pkg::PARAM_SLOTS - 1)) ? '0 : i + 1'b1;
  endfunction

  assign in_i.ready = q_ready_i;
  assign fire = in_i.valid && q_ready_i;

  // Text grid size, at least one cell each way.
  always_comb begin
    rows = (scr_h_q[11:GH_SH] == '0) ? 8'd1 : 8'(scr_h_q[11:GH_SH]);
    cols = (scr_w_q[11:GW_SH] == '0) ? 9'd1 : 9'(scr_w_q[11:GW_SH]);
  end

  // Per-byte state update and command list.
  always_comb begin
    atce_pkg::job_t j;
    logic [7:0]  b;
    logic [23:0] fg, bg;
    logic [19:0] v;
    logic [atce_pkg::PARAM_SLOTS-1:0][15:0] ts;
    logic [SW-1:0] ti;
    logic [2:0]  cnt;
    logic [15:0] r16, c16;
    logic [8:0]  r;
    logic [9:0]  c;
    logic [12:0] y;
    logic [11:0] x;
    logic [48:0] st;
    logic        is_digit;

    j = '0;
    b = in_i.byte_in;
    fg = rev_q ? grd_q : fore_q;
    bg = rev_q ? fore_q : grd_q;
    is_digit = (b >= CH_0) && (b <= CH_9);
    v = 20'(dv_q) * 20'd10 + 20'(b - CH_0);
    ts = slots_q;
    ti = idx_q;
    cnt = '0;
    r16 = '0;
    c16 = '0;
    r = 9'(row_q);
    c = 10'(col_q);
    y = '0;
    x = 12'({col_q, {GW_SH{1'b0}}});
    st = '0;

    mode_d = mode_q;
    dv_d = dv_q;
    dc_d = dc_q;
    slots_d = slots_q;
    idx_d = idx_q;
    row_d = row_q;
    col_d = col_q;
    fore_d = fore_q;
    grd_d = grd_q;
    rev_d = rev_q;
    shown_d = shown_q;
    disc_d = disc_q;

    if (fire) begin
      if (disc_q) begin
        // Dropping the rest of a write after a backspace at the origin.
        if (in_i.end_of_write) disc_d = 1'b0;
      end else begin
        unique case (mode_q)
          MODE_ESC: begin
            mode_d = (b == CH_LBR) ? MODE_CSI : MODE_NORMAL;
          end
          MODE_CSI: begin
            if (is_digit) begin
              dv_d = (v > 20'd65535) ? 16'hFFFF : v[15:0];
              dc_d = (dc_q < 4'd15) ? dc_q + 4'd1 : dc_q;
            end else if (b == CH_SEMI) begin
              slots_d[idx_q] = dv_q;
              idx_d = next_idx(idx_q);
              dv_d = '0;
              dc_d = '0;
            end else if (b == CH_QUES) begin
              dv_d = '0;
              dc_d = '0;
              slots_d = '0;
              mode_d = MODE_PRIV;
            end else begin
              mode_d = MODE_NORMAL;
              dv_d = '0;
              dc_d = '0;
              if (dc_q != '0) begin
                ts[idx_q] = dv_q;
                ti = next_idx(idx_q);
              end
              if (b == CH_H) begin
                // Cursor position, one-based row and column, clamped.
                r16 = (ti != '0 && ts[0] != '0) ? ts[0] - 16'd1 : '0;
                c16 = (ti > SW'(1) && ts[1 % atce_pkg::PARAM_SLOTS] != '0) ?
                      ts[1 % atce_pkg::PARAM_SLOTS] - 16'd1 : '0;
                row_d = (r16 >= 16'(rows)) ? rows - 8'd1 : r16[7:0];
                col_d = (c16 >= 16'(cols)) ? cols - 9'd1 : c16[8:0];
                slots_d = ts;
                idx_d = '0;
              end else if (b == CH_J) begin
                if (dc_q != '0 && dv_q == 16'd2) begin
                  j = put(j, mk(atce_pkg::CMD_FILL, 12'd0, 12'd0, scr_w_q, scr_h_q,
                                bg, 24'd0, 8'd0));
                  row_d = '0;
                  col_d = '0;
                end else begin
                  j = put(j, mk(atce_pkg::CMD_FILL, x, 12'({row_q, {GH_SH{1'b0}}}),
                                (scr_w_q > x) ? scr_w_q - x : 12'd0,
                                12'(atce_pkg::GLYPH_H), bg, 24'd0, 8'd0));
                  if (9'(row_q) + 9'd1 < 9'(rows)) begin
                    y = 13'({9'(row_q) + 9'd1, {GH_SH{1'b0}}});
                    j = put(j, mk(atce_pkg::CMD_FILL, 12'd0, y[11:0], scr_w_q,
                                  (13'(scr_h_q) > y) ? 12'(13'(scr_h_q) - y) : 12'd0,
                                  bg, 24'd0, 8'd0));
                  end
                end
              end else if (b == CH_K) begin
                j = put(j, mk(atce_pkg::CMD_FILL, x, 12'({row_q, {GH_SH{1'b0}}}),
                              (scr_w_q > x) ? scr_w_q - x : 12'd0,
                              12'(atce_pkg::GLYPH_H), bg, 24'd0, 8'd0));
              end else if (b == CH_M) begin
                // Color selection; no parameter means reset.
                cnt = 3'(ti);
                if (ti == '0) begin
                  ts[0] = '0;
                  cnt = 3'd1;
                end
                st = {fore_q, grd_q, rev_q};
                for (int p = 0; p < atce_pkg::PARAM_SLOTS; p++) begin
                  if (3'(p) < cnt) st = sgr(ts[p], st);
                end
                {fore_d, grd_d, rev_d} = st;
                slots_d = ts;
                idx_d = '0;
              end
            end
          end
          MODE_PRIV: begin
            if (is_digit) begin
              dv_d = (v > 20'd65535) ? 16'hFFFF : v[15:0];
              dc_d = (dc_q < 4'd15) ? dc_q + 4'd1 : dc_q;
            end else begin
              if ((b == CH_LO_L || b == CH_LO_H) && dv_q == 16'd25) begin
                shown_d = (b == CH_LO_H);
                if (col_q < cols && row_q < rows)
                  j = put(j, cursor_cell(10'(col_q), 9'(row_q),
                                         (b == CH_LO_H) ? fg : bg));
              end
              dv_d = '0;
              dc_d = '0;
              mode_d = MODE_NORMAL;
            end
          end
          default: begin
            if (b == CH_ESC) begin
              mode_d = MODE_ESC;
              idx_d = '0;
              slots_d = '0;
            end else begin
              // Erase the cursor cell before anything moves.
              if (shown_q && col_q < cols && row_q < rows)
                j = put(j, cursor_cell(10'(col_q), 9'(row_q), bg));
              if (b == CH_CR) begin
                col_d = '0;
              end else if (b == CH_BS) begin
                if (col_q == '0 && row_q == '0) begin
                  if (!in_i.end_of_write) disc_d = 1'b1;
                end else begin
                  if (c == '0) begin
                    r = r - 9'd1;
                    c = 10'(cols);
                  end
                  c = c - 10'd1;
                  row_d = r[7:0];
                  col_d = c[8:0];
                  j = put(j, cursor_cell(c, r, shown_q ? fg : bg));
                end
              end else if (b == CH_LF) begin
                r = r + 9'd1;
                col_d = '0;
                if (r >= 9'(rows)) begin
                  j = put(j, mk(atce_pkg::CMD_SCROLL, 12'd0, 12'd0, scr_w_q,
                                12'(atce_pkg::GLYPH_H), 24'd0, bg, 8'd0));
                  r = 9'(rows) - 9'd1;
                end
                row_d = r[7:0];
              end else if (b == CH_TAB) begin
                c = c + (10'd8 - 10'(c[2:0]));
                if (c >= 10'(cols)) begin
                  c = '0;
                  r = r + 9'd1;
                end
                if (r >= 9'(rows)) begin
                  j = put(j, mk(atce_pkg::CMD_SCROLL, 12'd0, 12'd0, scr_w_q,
                                12'(atce_pkg::GLYPH_H), 24'd0, bg, 8'd0));
                  r = 9'(rows) - 9'd1;
                end
                row_d = r[7:0];
                col_d = c[8:0];
              end else begin
                // Printable: wrap, scroll, glyph, then the cursor after it.
                if (c >= 10'(cols)) begin
                  r = r + 9'd1;
                  c = '0;
                end
                if (r >= 9'(rows)) begin
                  j = put(j, mk(atce_pkg::CMD_SCROLL, 12'd0, 12'd0, scr_w_q,
                                12'(atce_pkg::GLYPH_H), 24'd0, bg, 8'd0));
                  r = 9'(rows) - 9'd1;
                end
                j = put(j, mk(atce_pkg::CMD_GLYPH, 12'({c, {GW_SH{1'b0}}}),
                              12'({r, {GH_SH{1'b0}}}), 12'(atce_pkg::GLYPH_W),
                              12'(atce_pkg::GLYPH_H), fg, bg, b));
                c = c + 10'd1;
                if (shown_q && c < 10'(cols) && r < 9'(rows)) j = put(j, cursor_cell(c, r, fg));
                row_d = r[7:0];
                col_d = c[8:0];
              end
            end
          end
        endcase
      end
    end

    q_job_o = j;
    q_push_o = fire && (j.count != '0);
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= 12'd640;
      scr_h_q <= 12'd480;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == atce_pkg::REG_SCREEN_WIDTH) scr_w_q <= cfg_data_i;
      if (cfg_idx_i == atce_pkg::REG_SCREEN_HEIGHT) scr_h_q <= cfg_data_i;
    end
  end

  // Parser and console state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_NORMAL;
      dv_q    <= '0;
      dc_q    <= '0;
      slots_q <= '0;
      idx_q   <= '0;
      row_q   <= '0;
      col_q   <= '0;
      fore_q  <= 24'hFFFFFF;
      grd_q   <= '0;
      rev_q   <= 1'b0;
      shown_q <= 1'b1;
      disc_q  <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      dv_q    <= dv_d;
      dc_q    <= dc_d;
      slots_q <= slots_d;
      idx_q   <= idx_d;
      row_q   <= row_d;
      col_q   <= col_d;
      fore_q  <= fore_d;
      grd_q   <= grd_d;
      rev_q   <= rev_d;
      shown_q <= shown_d;
      disc_q  <= disc_d;
    end
  end

endmodule
`default_nettype wire

### rtl/core/atce_queue.sv
// Two-entry queue of command lists between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module atce_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire atce_pkg::job_t push_job_i,
  output logic                ready_o,
  input  wire logic           pop_i,
  output logic                head_valid_o,
  output atce_pkg::job_t      head_job_o
);

  atce_pkg::job_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign ready_o = (cnt_q != 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_job_o = mem_q[rd_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_job_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule
`default_nettype wire

### rtl/core/atce_back.sv
// Back end: hands out the commands of each list one word per cycle while out_o.ready is high.
`timescale 1ns / 1ps
`default_nettype none
module atce_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           head_valid_i,
  input  wire atce_pkg::job_t head_job_i,
  output logic                pop_o,
  atce_out_if.source          out_o
);

  logic [atce_pkg::RES_IDX_W-1:0] sel_q;
  logic           ov_q;
  atce_pkg::cmd_t cmd_q;
  logic           last_q;
  logic           load, last;

  assign last = (atce_pkg::RES_CNT_W'(sel_q) + 1'b1) == head_job_i.count;
  assign load = head_valid_i && (!ov_q || out_o.ready);
  assign pop_o = load && last;

  // Output register and position within the current list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      sel_q <= '0;
    end else begin
      if (load) begin
        ov_q  <= 1'b1;
        sel_q <= last ? '0 : sel_q + 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q  <= head_job_i.cmds[sel_q];
      last_q <= last;
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.command     = cmd_q.command;
  assign out_o.x_px        = cmd_q.x_px;
  assign out_o.y_px        = cmd_q.y_px;
  assign out_o.width_px    = cmd_q.width_px;
  assign out_o.height_px   = cmd_q.height_px;
  assign out_o.paint_color = cmd_q.paint_color;
  assign out_o.back_color  = cmd_q.back_color;
  assign out_o.glyph_code  = cmd_q.glyph_code;
  assign out_o.last_result = last_q;

endmodule
`default_nettype wire

### rtl/core/ansi_text_console_engine.sv
// Top level of the text console engine.
`timescale 1ns / 1ps
`default_nettype none
// Console bytes enter on in_i and are parsed combinationally; each byte turns into zero
// to four drawing commands (fill, glyph, scroll) that leave on out_o one word per cycle
// while the receiver is ready, with last_result marking the final command of a byte. A
// printed character with a visible cursor gives up to four commands. A two-entry queue
// between parser and output lets input keep flowing while commands wait, until it is full.
// Screen size registers are written through cfg_we_i, cfg_idx_i and cfg_data_i; the user
// must do so only while the block is idle, which the block itself does not enforce.
module ansi_text_console_engine (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  atce_in_if.sink                              in_i,
  atce_out_if.source                           out_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [atce_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [atce_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic           q_ready, q_push, head_valid, pop;
  atce_pkg::job_t push_job, head_job;

  atce_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .q_job_o    (push_job)
  );

  atce_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_job_i   (push_job),
    .ready_o      (q_ready),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_job_o   (head_job)
  );

  atce_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule
`default_nettype wire

### bench/ansi_text_console_engine_tb.sv
// Self-checking testbench of the text console engine: byte stream in, drawing commands out.
`timescale 1ns / 1ps
module ansi_text_console_engine_tb;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASES       = 6;
  localparam int PHASE_WORDS  = 70;

  // Console byte codes.
  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LBR  = "[";
  localparam logic [7:0] CH_SEMI = ";";
  localparam logic [7:0] CH_QUES = "?";
  localparam logic [7:0] CH_ZERO = "0";
  localparam logic [7:0] CH_NINE = "9";
  localparam logic [7:0] CH_H    = "H";
  localparam logic [7:0] CH_J    = "J";
  localparam logic [7:0] CH_K    = "K";
  localparam logic [7:0] CH_M    = "m";
  localparam logic [7:0] CH_SHOW = "h";
  localparam logic [7:0] CH_HIDE = "l";

  // Parameter values with a meaning of their own.
  localparam int ERASE_ALL     = 2;
  localparam int CURSOR_MODE   = 25;
  localparam int DIGIT_MAX     = 65535;
  localparam int DIGIT_CNT_MAX = 15;

  typedef enum logic [1:0] {PM_NORMAL, PM_ESC, PM_CSI, PM_PRIV} parse_e;

  typedef struct {
    atce_pkg::cmd_t c;
    logic last;
  } draw_t;

  typedef struct {
    logic [7:0] b;
    bit         eow;
    int         ntyped;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [atce_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [atce_pkg::CFG_DATA_W-1:0] cfg_data;

  atce_in_if  in_ch ();
  atce_out_if out_ch ();

  ansi_text_console_engine u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow state of the console.
  int unsigned scr_w, scr_h;
  parse_e      pmode;
  int unsigned dval, dcnt, pidx, crow, ccol;
  int unsigned slot [atce_pkg::PARAM_SLOTS];
  logic [23:0] fore, grnd;
  bit          rev, shown, drop;

  draw_t byte_cmds[$];
  draw_t draw_q[$];
  draw_t typed_pend[$];
  bit    use_typed = 1'b0;
  int    errors = 0;
  int    cycles = 0;
  int    src_idle = 36;
  int    snk_idle = 69;
  int    hold_token = 0;
  int    words_sent = 0;

  function automatic int unsigned text_cols();
    int unsigned c;
    c = scr_w / atce_pkg::GLYPH_W;
    return (c != 0) ? c : 1;
  endfunction

  function automatic int unsigned text_rows();
    int unsigned r;
    r = scr_h / atce_pkg::GLYPH_H;
    return (r != 0) ? r : 1;
  endfunction

  function automatic draw_t mk_draw(atce_pkg::cmd_e cmd, int unsigned x, int unsigned y,
                                    int unsigned w, int unsigned h, logic [23:0] paint,
                                    logic [23:0] back, logic [7:0] g, logic last);
    draw_t d;
    d.c.command     = cmd;
    d.c.x_px        = x[11:0];
    d.c.y_px        = y[11:0];
    d.c.width_px    = w[11:0];
    d.c.height_px   = h[11:0];
    d.c.paint_color = paint;
    d.c.back_color  = back;
    d.c.glyph_code  = g;
    d.last          = last;
    return d;
  endfunction

  // A byte causes at most MAX_RESULTS commands; extra ones are dropped.
  function automatic void emit(atce_pkg::cmd_e cmd, int unsigned x, int unsigned y,
                               int unsigned w, int unsigned h, logic [23:0] paint,
                               logic [23:0] back, logic [7:0] g);
    if (byte_cmds.size() < atce_pkg::MAX_RESULTS)
      byte_cmds.push_back(mk_draw(cmd, x, y, w, h, paint, back, g, 1'b0));
  endfunction

  function automatic void paint_cell(logic [23:0] color);
    emit(atce_pkg::CMD_FILL, ccol * atce_pkg::GLYPH_W, crow * atce_pkg::GLYPH_H,
         atce_pkg::GLYPH_W, atce_pkg::GLYPH_H, color, '0, '0);
  endfunction

  function automatic bit cursor_in();
    return ccol < text_cols() && crow < text_rows();
  endfunction

  function automatic void scroll_up(logic [23:0] bg);
    crow = text_rows() - 1;
    emit(atce_pkg::CMD_SCROLL, 0, 0, scr_w, atce_pkg::GLYPH_H, '0, bg, '0);
  endfunction

  function automatic void erase_line_rest(logic [23:0] bg);
    int unsigned x;
    x = ccol * atce_pkg::GLYPH_W;
    emit(atce_pkg::CMD_FILL, x, crow * atce_pkg::GLYPH_H, (scr_w > x) ? scr_w - x : 0,
         atce_pkg::GLYPH_H, bg, '0, '0);
  endfunction

  function automatic void push_param();
    slot[pidx % atce_pkg::PARAM_SLOTS] = dval;
    pidx = (pidx + 1) % atce_pkg::PARAM_SLOTS;
  endfunction

  function automatic void take_digit(logic [7:0] b);
    int unsigned v;
    v = dval * 10 + (b - CH_ZERO);
    dval = (v > DIGIT_MAX) ? DIGIT_MAX : v;
    if (dcnt < DIGIT_CNT_MAX) dcnt++;
  endfunction

  function automatic void clear_params();
    foreach (slot[i]) slot[i] = 0;
  endfunction

  // Select graphic rendition from the fixed palette.
  function automatic void apply_rendition(int unsigned p);
    case (p)
      0: begin
        fore = 24'hFFFFFF;
        grnd = 24'h000000;
        rev  = 1'b0;
      end
      7:  rev = 1'b1;
      27: rev = 1'b0;
      30: fore = 24'h414868;
      31: fore = 24'hF7768E;
      32: fore = 24'h9ECE6A;
      33: fore = 24'hE0AF68;
      34: fore = 24'h7AA2F7;
      35: fore = 24'hBB9AF7;
      36: fore = 24'h7DCFFF;
      37: fore = 24'hA9B1D6;
      39: fore = 24'hC0CAF5;
      40: grnd = 24'h1A1B26;
      41: grnd = 24'hF7768E;
      42: grnd = 24'h9ECE6A;
      43: grnd = 24'hE0AF68;
      44: grnd = 24'h7AA2F7;
      45: grnd = 24'hBB9AF7;
      46: grnd = 24'h7DCFFF;
      47: grnd = 24'hA9B1D6;
      49: grnd = 24'h000000;
      90: fore = 24'h565F89;
      91: fore = 24'hFF9E9E;
      92: fore = 24'hC3E88D;
      93: fore = 24'hFFD580;
      94: fore = 24'h82AAFF;
      95: fore = 24'hC3A6FF;
      96: fore = 24'hB4F9F8;
      97: fore = 24'hC0CAF5;
      default: ;
    endcase
  endfunction

  function automatic void csi_step(logic [7:0] b, logic [23:0] bg);
    int unsigned r, c, y;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      take_digit(b);
      return;
    end
    if (b == CH_SEMI) begin
      push_param();
      dval = 0;
      dcnt = 0;
      return;
    end
    if (b == CH_QUES) begin
      dval = 0;
      dcnt = 0;
      clear_params();
      pmode = PM_PRIV;
      return;
    end
    pmode = PM_NORMAL;
    if (b == CH_H) begin
      if (dcnt != 0) push_param();
      r = (pidx > 0 && slot[0] > 0) ? slot[0] - 1 : 0;
      c = (pidx > 1 && slot[1] > 0) ? slot[1] - 1 : 0;
      crow = (r >= text_rows()) ? text_rows() - 1 : r;
      ccol = (c >= text_cols()) ? text_cols() - 1 : c;
      pidx = 0;
    end else if (b == CH_J) begin
      if (dcnt != 0 && dval == ERASE_ALL) begin
        emit(atce_pkg::CMD_FILL, 0, 0, scr_w, scr_h, bg, '0, '0);
        crow = 0;
        ccol = 0;
      end else begin
        erase_line_rest(bg);
        if (crow + 1 < text_rows()) begin
          y = (crow + 1) * atce_pkg::GLYPH_H;
          emit(atce_pkg::CMD_FILL, 0, y, scr_w, (scr_h > y) ? scr_h - y : 0, bg, '0, '0);
        end
      end
    end else if (b == CH_K) begin
      erase_line_rest(bg);
    end else if (b == CH_M) begin
      if (dcnt != 0) push_param();
      if (pidx == 0) begin
        slot[0] = 0;
        pidx = 1;
      end
      for (int p = 0; p < pidx && p < atce_pkg::PARAM_SLOTS; p++) apply_rendition(slot[p]);
      pidx = 0;
    end
    dval = 0;
    dcnt = 0;
  endfunction

  function automatic void priv_step(logic [7:0] b, logic [23:0] fg, logic [23:0] bg);
    if (b >= CH_ZERO && b <= CH_NINE) begin
      take_digit(b);
      return;
    end
    if (b == CH_HIDE || b == CH_SHOW) begin
      slot[pidx % atce_pkg::PARAM_SLOTS] = dval;
      if (dval == CURSOR_MODE) begin
        shown = (b == CH_SHOW);
        if (cursor_in()) paint_cell((b == CH_SHOW) ? fg : bg);
      end
    end
    dval = 0;
    dcnt = 0;
    pmode = PM_NORMAL;
  endfunction

  function automatic void plain_step(logic [7:0] b, bit eow, logic [23:0] fg, logic [23:0] bg);
    if (b == CH_ESC) begin
      pmode = PM_ESC;
      pidx = 0;
      clear_params();
      return;
    end
    if (shown && cursor_in()) paint_cell(bg);
    case (b)
      CH_CR: ccol = 0;
      CH_BS: begin
        if (ccol == 0 && crow == 0) begin
          // Backspace at the origin drops the rest of the write.
          if (!eow) drop = 1'b1;
        end else begin
          if (ccol == 0) begin
            crow--;
            ccol = text_cols();
          end
          ccol--;
          paint_cell(shown ? fg : bg);
        end
      end
      CH_LF: begin
        crow++;
        ccol = 0;
        if (crow >= text_rows()) scroll_up(bg);
      end
      CH_TAB: begin
        ccol += 8 - (ccol % 8);
        if (ccol >= text_cols()) begin
          ccol = 0;
          crow++;
        end
        if (crow >= text_rows()) scroll_up(bg);
      end
      default: begin
        if (ccol >= text_cols()) begin
          crow++;
          ccol = 0;
        end
        if (crow >= text_rows()) scroll_up(bg);
        emit(atce_pkg::CMD_GLYPH, ccol * atce_pkg::GLYPH_W, crow * atce_pkg::GLYPH_H,
             atce_pkg::GLYPH_W, atce_pkg::GLYPH_H, fg, bg, b);
        ccol++;
        if (shown && cursor_in()) paint_cell(fg);
      end
    endcase
  endfunction

  // Work out the drawing commands that one console byte causes.
  function automatic void predict_byte(logic [7:0] b, bit eow);
    logic [23:0] fg, bg;
    fg = rev ? grnd : fore;
    bg = rev ? fore : grnd;
    byte_cmds.delete();
    if (drop) begin
      if (eow) drop = 1'b0;
      return;
    end
    case (pmode)
      PM_ESC:  pmode = (b == CH_LBR) ? PM_CSI : PM_NORMAL;
      PM_CSI:  csi_step(b, bg);
      PM_PRIV: priv_step(b, fg, bg);
      default: plain_step(b, eow, fg, bg);
    endcase
    if (byte_cmds.size() > 0) byte_cmds[byte_cmds.size() - 1].last = 1'b1;
  endfunction

  function automatic void console_reset();
    scr_w = 640;
    scr_h = 480;
    pmode = PM_NORMAL;
    dval  = 0;
    dcnt  = 0;
    pidx  = 0;
    clear_params();
    crow  = 0;
    ccol  = 0;
    fore  = 24'hFFFFFF;
    grnd  = 24'h000000;
    rev   = 1'b0;
    shown = 1'b1;
    drop  = 1'b0;
  endfunction

  function automatic void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Predict on every accepted byte.
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      predict_byte(in_ch.byte_in, in_ch.end_of_write);
      if (use_typed) begin
        foreach (typed_pend[i]) draw_q.push_back(typed_pend[i]);
        typed_pend.delete();
      end else begin
        foreach (byte_cmds[i]) draw_q.push_back(byte_cmds[i]);
      end
    end
  end

  // Compare every accepted drawing command with the oldest expected one.
  always @(posedge clk_i) begin : out_check
    draw_t d;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (draw_q.size() == 0) begin
        $error("drawing command with none expected");
        errors++;
      end else begin
        d = draw_q.pop_front();
        cmp_field("command", d.c.command, out_ch.command);
        cmp_field("x_px", d.c.x_px, out_ch.x_px);
        cmp_field("y_px", d.c.y_px, out_ch.y_px);
        cmp_field("width_px", d.c.width_px, out_ch.width_px);
        cmp_field("height_px", d.c.height_px, out_ch.height_px);
        cmp_field("paint_color", d.c.paint_color, out_ch.paint_color);
        cmp_field("back_color", d.c.back_color, out_ch.back_color);
        cmp_field("glyph_code", d.c.glyph_code, out_ch.glyph_code);
        cmp_field("last_result", d.last, out_ch.last_result);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("ansi_text_console_engine_tb failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int hold_seen;
    hold_seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_ch.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  // Offer one word and wait until it is taken; called and returns at a falling edge.
  task automatic send_word(logic [7:0] b, bit eow);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.byte_in      <= b;
    in_ch.end_of_write <= eow;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic send_num(int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  function automatic bit rand_eow();
    return $urandom_range(7) == 0;
  endfunction

  // One random stretch of console traffic, mostly well-formed.
  task automatic send_random_seq();
    int kind, n, v;
    int unsigned rend [] = '{0, 7, 27, 30, 31, 32, 33, 34, 35, 36, 37, 39, 40, 41, 42, 43, 44,
                              45, 46, 47, 49, 90, 91, 92, 93, 94, 95, 96, 97};
    logic [7:0] ctl [] = '{CH_CR, CH_LF, CH_BS, CH_TAB};
    logic [7:0] fin [] = '{CH_H, CH_J, CH_K, CH_M};
    kind = $urandom_range(99);
    if (kind < 30) begin
      n = $urandom_range(1, 8);
      repeat (n) send_word(8'($urandom_range(32, 126)), rand_eow());
    end else if (kind < 42) begin
      send_word(ctl[$urandom_range(3)], rand_eow());
    end else if (kind < 46) begin
      // Escape followed by something other than a bracket.
      send_word(CH_ESC, 1'b0);
      send_word(8'($urandom_range(255)), rand_eow());
    end else if (kind < 72) begin
      send_word(CH_ESC, 1'b0);
      send_word(CH_LBR, 1'b0);
      n = $urandom_range(0, 6);
      v = $urandom_range(3);
      for (int i = 0; i < n; i++) begin
        if (i != 0) send_word(CH_SEMI, 1'b0);
        case ($urandom_range(9))
          0:       ;
          1:       send_num($urandom_range(0, 999999));
          2:       repeat (17) send_word(8'(CH_ZERO + $urandom_range(9)), 1'b0);
          3, 4, 5: send_num(rend[$urandom_range(rend.size() - 1)]);
          default: send_num($urandom_range(0, 90));
        endcase
      end
      if ($urandom_range(9) == 0) send_word(8'($urandom_range(255)), rand_eow());
      else send_word(fin[v], rand_eow());
    end else if (kind < 82) begin
      send_word(CH_ESC, 1'b0);
      send_word(CH_LBR, 1'b0);
      send_word(CH_QUES, 1'b0);
      send_num(($urandom_range(4) != 0) ? CURSOR_MODE : $urandom_range(0, 99));
      case ($urandom_range(4))
        0:       send_word(8'($urandom_range(255)), rand_eow());
        1, 2:    send_word(CH_HIDE, rand_eow());
        default: send_word(CH_SHOW, rand_eow());
      endcase
    end else if (kind < 90) begin
      // Home, then a backspace at the origin and what follows it in the write.
      send_word(CH_ESC, 1'b0);
      send_word(CH_LBR, 1'b0);
      send_word(CH_H, 1'b0);
      send_word(CH_BS, ($urandom_range(3) == 0));
      n = $urandom_range(1, 5);
      repeat (n) send_word(8'($urandom_range(255)), rand_eow());
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) send_word(8'($urandom_range(255)), rand_eow());
    end
  endtask

  task automatic wait_idle();
    while (draw_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [atce_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val[atce_pkg::CFG_DATA_W-1:0];
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == atce_pkg::REG_SCREEN_WIDTH) scr_w = val & 12'hFFF;
    else scr_h = val & 12'hFFF;
  endtask

  initial begin : stimulus
    row_t  rows [$];
    draw_t typed [$];
    int    ti;
    int unsigned widths  [PHASES] = '{8, 4095, 640, 0, 200, 4095};
    int unsigned heights [PHASES] = '{16, 4095, 480, 0, 50, 16};

    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.byte_in      = '0;
    in_ch.end_of_write = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = '0;
    cfg_data           = '0;
    console_reset();

    // Directed rows: printable at reset size, full erase, discard after home backspace,
    // byte extremes, control bytes, cursor hide and erase to end of line.
    rows = '{
      '{"A", 0, 3}, '{CH_ESC, 0, 0}, '{CH_LBR, 0, 0}, '{"2", 0, 0}, '{CH_J, 0, 1},
      '{CH_BS, 0, 0}, '{"x", 0, 0}, '{"y", 1, 0}, '{8'hFF, 0, 0}, '{8'h00, 1, 0},
      '{CH_TAB, 0, 0}, '{CH_CR, 0, 0}, '{CH_LF, 0, 0}, '{CH_BS, 1, 0},
      '{CH_ESC, 0, 0}, '{CH_LBR, 0, 0}, '{CH_QUES, 0, 0}, '{"2", 0, 0}, '{"5", 0, 0},
      '{CH_HIDE, 0, 0}, '{CH_ESC, 0, 0}, '{CH_LBR, 0, 0}, '{CH_K, 1, 0}
    };
    typed = '{
      mk_draw(atce_pkg::CMD_FILL, 0, 0, atce_pkg::GLYPH_W, atce_pkg::GLYPH_H, 24'h000000,
              '0, '0, 1'b0),
      mk_draw(atce_pkg::CMD_GLYPH, 0, 0, atce_pkg::GLYPH_W, atce_pkg::GLYPH_H, 24'hFFFFFF,
              24'h000000, "A", 1'b0),
      mk_draw(atce_pkg::CMD_FILL, atce_pkg::GLYPH_W, 0, atce_pkg::GLYPH_W, atce_pkg::GLYPH_H,
              24'hFFFFFF, '0, '0, 1'b1),
      mk_draw(atce_pkg::CMD_FILL, 0, 0, 640, 480, 24'h000000, '0, '0, 1'b1)
    };

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    ti = 0;
    foreach (rows[r]) begin
      if (rows[r].ntyped != 0) begin
        repeat (rows[r].ntyped) typed_pend.push_back(typed[ti++]);
        use_typed = 1'b1;
      end
      send_word(rows[r].b, rows[r].eow);
      use_typed = 1'b0;
    end
    in_ch.valid <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reg(atce_pkg::REG_SCREEN_WIDTH,
                (widths[p] != 0) ? widths[p] : $urandom_range(8, 4095));
      write_reg(atce_pkg::REG_SCREEN_HEIGHT,
                (heights[p] != 0) ? heights[p] : $urandom_range(16, 4095));
      src_idle = (p < 2) ? 36 : ((p < 4) ? 69 : 0);
      snk_idle = (p < 2) ? 69 : ((p < 4) ? 36 : 0);
      // Long receiver hold-off while bytes keep coming.
      if (p == 4) hold_token++;
      words_sent = 0;
      while (words_sent < PHASE_WORDS) send_random_seq();
      in_ch.valid <= 1'b0;
    end

    wait_idle();
    if (errors == 0 && draw_q.size() == 0) begin
      $display("ansi_text_console_engine_tb passed");
    end else begin
      if (draw_q.size() != 0) $error("%0d drawing commands never arrived", draw_q.size());
      $display("ansi_text_console_engine_tb failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/atce_pkg.sv
rtl/core/atce_if.sv
rtl/core/atce_front.sv
rtl/core/atce_queue.sv
rtl/core/atce_back.sv
rtl/core/ansi_text_console_engine.sv
bench/ansi_text_console_engine_tb.sv
